/* design/bsf_pkg.sv */
// Shared types and codes for the byte ring buffer with start-code framing.
package bsf_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_NODATA  = 2'd2;
    localparam logic [1:0] ST_NOFRAME = 2'd3;

    // Start code 00 00 01 and the minimum fill for a frame query
    localparam logic [7:0] SC_ZERO   = 8'h00;
    localparam logic [7:0] SC_ONE    = 8'h01;
    localparam int         MIN_FRAME = 5;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [6:0] read_length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_byte;
        logic [12:0] frame_length;
        logic        last;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SCAN = 3'b100
    } t_state;

endpackage

/* design/bsf_store.sv */
// Byte store: one write port, one read port with registered read data.
module bsf_store #(
    parameter int DEPTH = 4096,
    parameter int IW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write at the tail; read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bsf_outq.sv */
// Two-entry result queue that decouples the sequencer from the consumer.
module bsf_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enq,
    input  bsf_pkg::t_rsp i_data,
    output logic          o_valid,
    output bsf_pkg::t_rsp o_data,
    input  logic          i_ready,
    output logic [1:0]    o_count
);

    bsf_pkg::t_rsp r_data [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_pop;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_data[r_rp];
    assign o_count = r_cnt;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_enq) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_enq) - 2'(w_pop);
        end
    end

    // Hold entry payload
    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

/* design/byte_ring_buffer_start_code_framer_core.sv */
// A push or rejected request answers via the result register and result queue; a read
// run's first byte via the store read register and the queue, then one byte per cycle
// while the queue has room; pushes go at one per cycle on the same condition. A read run
// holds the store read port until its bytes are issued. A frame query walks the store one
// byte per cycle over the read port to the last stored byte. Synchronous active-low reset
// empties the ring (head, tail, fill zero); contents stay, never read before written.
module byte_ring_buffer_start_code_framer_core #(
    parameter int BUFFER_SIZE = 4096,
    parameter int MAX_READ    = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bsf_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output bsf_pkg::t_rsp o_rsp
);

    localparam int IW = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;
    localparam int CW = $clog2(BUFFER_SIZE + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    bsf_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_fill, n_fill;
    logic [6:0]      r_left, n_left;

    // Result stage ahead of the queue (registered alongside the store read data)
    logic            r_pv, n_pv;
    logic [1:0]      r_pst, n_pst;
    logic [12:0]     r_pflen, n_pflen;
    logic            r_plast, n_plast;
    logic            r_pmem, n_pmem;

    // Scan pipeline
    logic            r_sv, n_sv;
    logic [CW-1:0]   r_sj, n_sj;
    logic [CW-1:0]   r_soff, n_soff;
    logic [IW-1:0]   r_saddr, n_saddr;
    logic [7:0]      r_b1, n_b1;
    logic [7:0]      r_b2, n_b2;

    logic            mem_we;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata;

    bsf_pkg::t_rsp   w_enq_data;
    logic [1:0]      w_qcnt;
    logic            w_pop;
    logic            w_room;
    logic            w_accept;
    logic            w_full;
    logic            w_bad_len;
    logic [LW-1:0]   w_len_ext;
    logic [CW+12:0]  w_flen_ext;
    logic            w_match;

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] idx);
        return (idx == IW'(BUFFER_SIZE - 1)) ? '0 : idx + IW'(1);
    endfunction

    bsf_store #(
        .DEPTH (BUFFER_SIZE),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (i_req.data_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_enq_data.status       = r_pst;
    assign w_enq_data.out_byte     = r_pmem ? mem_rdata : 8'd0;
    assign w_enq_data.frame_length = r_pflen;
    assign w_enq_data.last         = r_plast;

    bsf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (r_pv),
        .i_data  (w_enq_data),
        .o_valid (o_rsp_valid),
        .o_data  (o_rsp),
        .i_ready (i_rsp_ready),
        .o_count (w_qcnt)
    );

    // Room for one more result once queued and in-flight results are counted
    assign w_pop       = o_rsp_valid && i_rsp_ready;
    assign w_room      = ((w_qcnt + 2'(r_pv)) < 2'd2) || w_pop;
    assign o_req_ready = (r_state == bsf_pkg::S_IDLE) && w_room;
    assign w_accept    = i_req_valid && o_req_ready;

    assign w_full     = (r_fill == CW'(BUFFER_SIZE));
    assign w_len_ext  = LW'(i_req.read_length);
    assign w_bad_len  = (i_req.read_length == 7'd0) || (w_len_ext > LW'(MAX_READ))
                        || (w_len_ext > LW'(r_fill));
    assign w_flen_ext = {13'd0, r_sj - CW'(2)};
    assign w_match    = (r_sj >= CW'(3)) && (r_b2 == bsf_pkg::SC_ZERO)
                        && (r_b1 == bsf_pkg::SC_ZERO) && (mem_rdata == bsf_pkg::SC_ONE);

    // Sequencer: decode requests, walk read runs and frame scans
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_left    = r_left;
        n_pv      = 1'b0;
        n_pst     = bsf_pkg::ST_OK;
        n_pflen   = 13'd0;
        n_plast   = 1'b1;
        n_pmem    = 1'b0;
        n_sv      = 1'b0;
        n_sj      = r_sj;
        n_soff    = r_soff;
        n_saddr   = r_saddr;
        n_b1      = r_b1;
        n_b2      = r_b2;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = r_head;

        unique case (r_state)
            bsf_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.func)
                        bsf_pkg::FUNC_PUSH: begin
                            // Store at tail; drop the oldest byte when full
                            mem_we = 1'b1;
                            n_tail = inc_idx(r_tail);
                            n_pv   = 1'b1;
                            if (w_full) begin
                                n_head = inc_idx(r_head);
                                n_pst  = bsf_pkg::ST_OVF;
                            end else begin
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        bsf_pkg::FUNC_READ: begin
                            n_pv = 1'b1;
                            if (w_bad_len) begin
                                n_pst = bsf_pkg::ST_NODATA;
                            end else begin
                                // Issue the first byte of the run
                                mem_re  = 1'b1;
                                n_pmem  = 1'b1;
                                n_plast = (i_req.read_length == 7'd1);
                                n_head  = inc_idx(r_head);
                                n_fill  = r_fill - CW'(1);
                                n_left  = i_req.read_length - 7'd1;
                                if (i_req.read_length != 7'd1) begin
                                    n_state = bsf_pkg::S_READ;
                                end
                            end
                        end
                        bsf_pkg::FUNC_QUERY: begin
                            if (r_fill < CW'(bsf_pkg::MIN_FRAME)) begin
                                n_pv  = 1'b1;
                                n_pst = bsf_pkg::ST_NODATA;
                            end else begin
                                n_state = bsf_pkg::S_SCAN;
                                n_soff  = CW'(1);
                                n_saddr = inc_idx(r_head);
                            end
                        end
                        default: begin
                            // Unused function: drop the request
                        end
                    endcase
                end
            end
            bsf_pkg::S_READ: begin
                // Issue one byte per cycle while the queue has room
                if (w_room) begin
                    mem_re  = 1'b1;
                    n_pv    = 1'b1;
                    n_pmem  = 1'b1;
                    n_plast = (r_left == 7'd1);
                    n_head  = inc_idx(r_head);
                    n_fill  = r_fill - CW'(1);
                    n_left  = r_left - 7'd1;
                    if (r_left == 7'd1) begin
                        n_state = bsf_pkg::S_IDLE;
                    end
                end
            end
            bsf_pkg::S_SCAN: begin
                // Issue the next offset up to the last stored byte
                if (r_soff < r_fill) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_saddr;
                    n_sv      = 1'b1;
                    n_sj      = r_soff;
                    n_soff    = r_soff + CW'(1);
                    n_saddr   = inc_idx(r_saddr);
                end
                // Check the returned byte against the two before it
                if (r_sv) begin
                    n_b1 = mem_rdata;
                    n_b2 = r_b1;
                    if (w_match) begin
                        n_pv    = 1'b1;
                        n_pflen = w_flen_ext[12:0];
                        n_sv    = 1'b0;
                        n_state = bsf_pkg::S_IDLE;
                    end else if (r_sj == r_fill - CW'(1)) begin
                        n_pv    = 1'b1;
                        n_pst   = bsf_pkg::ST_NOFRAME;
                        n_sv    = 1'b0;
                        n_state = bsf_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bsf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsf_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_left  <= '0;
            r_pv    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_pv    <= n_pv;
            r_sv    <= n_sv;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pst   <= n_pst;
        r_pflen <= n_pflen;
        r_plast <= n_plast;
        r_pmem  <= n_pmem;
        r_sj    <= n_sj;
        r_soff  <= n_soff;
        r_saddr <= n_saddr;
        r_b1    <= n_b1;
        r_b2    <= n_b2;
    end

    // Queue never overcommitted by results in flight
    a_no_overcommit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qcnt + 2'(r_pv)) <= 2'd2)
        else $error("result queue overcommitted");

    // Fill count stays within the ring
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(BUFFER_SIZE))
        else $error("fill count above buffer size");

    // A read run always has bytes left while it is active
    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsf_pkg::S_READ) |-> (r_left != 7'd0))
        else $error("read run active with no bytes left");

    // Scan data only follows a scan cycle
    a_scan_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> $past(r_state == bsf_pkg::S_SCAN))
        else $error("scan data outside a scan");

    // Read runs do not mix with scan traffic
    a_run_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && r_pmem) |-> !r_sv)
        else $error("read run overlaps frame scan");

endmodule
